// ===== design/ils_pkg.sv =====
package ils_pkg;

  // Default list capacity and the word width of one entry.
  localparam int DefCapacity = 256;
  localparam int DataW       = 32;

  // Command codes carried in the command field.
  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_READ   = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What every cell of the chain does at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e         mode;
    logic               sample;
    logic [DataW-1:0]   value;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [8:0]         index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [8:0]         count;
  } out_item_t;

endpackage

// ===== design/indexed_list_store_core.sv =====
// An accepted item's result is presented once the registered OR tree that
// collects the read word from the cell chain has delivered it. One item is
// handled at a time, so a new item is taken only after the previous result
// has left the output. Reset clears the entry count and the control state;
// stored words stay unset.
module indexed_list_store_core #(
  parameter int CAPACITY = ils_pkg::DefCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ils_pkg::in_item_t in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ils_pkg::out_item_t out_o
);
  import ils_pkg::*;

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int W      = (CW > 9) ? CW : 9;
  localparam int Levels = $clog2(CAPACITY);
  localparam int WW     = $clog2(Levels + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_SEND
  } state_e;

  state_e           state_q;
  logic [CW-1:0]    count_q, count_d;
  status_e          status_q, status_d;
  logic             rd_ok_q, rd_ok_d;
  logic [WW-1:0]    wait_q;

  logic             accept;
  logic [W-1:0]     cnt_x, idx_x;
  logic             full, empty;
  cell_ctrl_t       ctrl;
  logic [CW-1:0]    target, rd_target;

  logic [DataW-1:0]                cell_data [CAPACITY];
  logic [CAPACITY-1:0][DataW-1:0]  leaves;
  logic [DataW-1:0]                root;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign cnt_x  = W'(count_q);
  assign idx_x  = W'(in_i.index);
  assign full   = (cnt_x == W'(CAPACITY));
  assign empty  = (count_q == '0);

  // Decode the command against the current count and steer the cell chain.
  always_comb begin
    status_d    = ST_RANGE;
    rd_ok_d     = 1'b0;
    count_d     = count_q;
    ctrl.mode   = CELL_HOLD;
    ctrl.sample = accept;
    ctrl.value  = in_i.value;
    target      = idx_x[CW-1:0];
    rd_target   = idx_x[CW-1:0];
    case (in_i.command)
      CMD_PUSH: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d  = ST_DONE;
          ctrl.mode = CELL_INSERT;
          target    = count_q;
          count_d   = count_q + 1'b1;
        end
      end
      CMD_POP: begin
        if (!empty) begin
          status_d  = ST_DONE;
          rd_ok_d   = 1'b1;
          rd_target = count_q - 1'b1;
          count_d   = count_q - 1'b1;
        end
      end
      CMD_READ: begin
        if (idx_x < cnt_x) begin
          status_d = ST_DONE;
          rd_ok_d  = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (idx_x <= cnt_x) begin
          status_d  = ST_DONE;
          ctrl.mode = CELL_INSERT;
          count_d   = count_q + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (idx_x < cnt_x) begin
          status_d  = ST_DONE;
          rd_ok_d   = 1'b1;
          ctrl.mode = CELL_REMOVE;
          count_d   = count_q - 1'b1;
        end
      end
      default: status_d = ST_RANGE;
    endcase
    if (!accept) begin
      ctrl.mode = CELL_HOLD;
    end
  end

  // Sequencer: accept, wait for the read tree, then present the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      status_q <= ST_DONE;
      rd_ok_q  <= 1'b0;
      wait_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q  <= S_WORK;
            count_q  <= count_d;
            status_q <= status_d;
            rd_ok_q  <= rd_ok_d;
            wait_q   <= WW'(Levels - 1);
          end
        end
        S_WORK: begin
          if (wait_q == '0) begin
            state_q <= S_SEND;
          end else begin
            wait_q <= wait_q - 1'b1;
          end
        end
        S_SEND: begin
          if (!out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The chain of storage cells, each wired to its neighbors (zero past either end).
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    if (j == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[j-1];
    end
    if (j == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[j+1];
    end
    ils_cell #(
      .POS (j),
      .PW  (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .target_i    (target),
      .rd_target_i (rd_target),
      .left_i      (left_w),
      .right_i     (right_w),
      .data_o      (cell_data[j]),
      .leaf_o      (leaves[j])
    );
  end

  // Registered OR tree gathers the one selected word.
  ils_or_tree #(
    .N  (CAPACITY),
    .DW (DataW)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (leaves),
    .root_o (root)
  );

  // Result item.
  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = (state_q == S_SEND);
  assign out_o.status     = status_q;
  assign out_o.read_value = rd_ok_q ? root : '0;
  assign out_o.count      = cnt_x[8:0];

endmodule

// ===== design/ils_cell.sv =====
module ils_cell #(
  parameter int POS = 0,
  parameter int PW  = $clog2(ils_pkg::DefCapacity + 1)
) (
  input  logic                        clk_i,
  input  ils_pkg::cell_ctrl_t         ctrl_i,
  input  logic [PW-1:0]               target_i,
  input  logic [PW-1:0]               rd_target_i,
  input  logic [ils_pkg::DataW-1:0]   left_i,
  input  logic [ils_pkg::DataW-1:0]   right_i,
  output logic [ils_pkg::DataW-1:0]   data_o,
  output logic [ils_pkg::DataW-1:0]   leaf_o
);
  import ils_pkg::*;

  localparam logic [PW-1:0] MyPos = PW'(POS);

  logic [DataW-1:0] data_q, data_d;
  logic [DataW-1:0] leaf_q;

  // Next word: load the new value, take the left neighbor's word on an
  // insert above the target, or the right one's at or above it on a remove.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.mode)
      CELL_INSERT: begin
        if (MyPos == target_i) begin
          data_d = ctrl_i.value;
        end else if (MyPos > target_i) begin
          data_d = left_i;
        end
      end
      CELL_REMOVE: begin
        if (MyPos >= target_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // The stored word and the read leaf, which captures the word before the
  // update when this cell is the read position.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (ctrl_i.sample) begin
      leaf_q <= (MyPos == rd_target_i) ? data_q : '0;
    end
  end

  assign data_o = data_q;
  assign leaf_o = leaf_q;

endmodule

// ===== design/ils_or_tree.sv =====
module ils_or_tree #(
  parameter int N  = ils_pkg::DefCapacity,
  parameter int DW = ils_pkg::DataW
) (
  input  logic                  clk_i,
  input  logic [N-1:0][DW-1:0]  leaf_i,
  output logic [DW-1:0]         root_o
);

  localparam int Levels = $clog2(N);
  localparam int Pad    = 1 << Levels;
  localparam int Inner  = Pad - 1;

  logic [DW-1:0] leaf_pad [Pad];
  logic [DW-1:0] node_q   [Inner];

  // Leaves padded with zeros up to a power of two.
  for (genvar k = 0; k < Pad; k++) begin : g_leaf
    if (k < N) begin : g_used
      assign leaf_pad[k] = leaf_i[k];
    end else begin : g_zero
      assign leaf_pad[k] = '0;
    end
  end

  // One register per tree node; at most one leaf is nonzero, so OR selects it.
  for (genvar i = 0; i < Inner; i++) begin : g_node
    localparam int C = 2 * i + 1;
    if (C >= Inner) begin : g_bottom
      always_ff @(posedge clk_i) begin
        node_q[i] <= leaf_pad[C-Inner] | leaf_pad[C+1-Inner];
      end
    end else begin : g_upper
      always_ff @(posedge clk_i) begin
        node_q[i] <= node_q[C] | node_q[C+1];
      end
    end
  end

  assign root_o = node_q[0];

endmodule

// ===== design/ils_checker.sv =====
module ils_checker #(
  parameter int CAPACITY = ils_pkg::DefCapacity
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input ils_pkg::in_item_t  in_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ils_pkg::out_item_t out_o
);
  import ils_pkg::*;

  // A refused command never returns a stale word.
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != ST_DONE) |-> (out_o.read_value == '0))
    else $error("refused item carries a nonzero word");

  // The reported count never passes the capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_o.count) <= CAPACITY))
    else $error("count beyond capacity");

  // Only one item is in flight: no item is taken while a result waits.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("item accepted while a result is pending");

  // A result never appears in the cycle right after an accept.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result appeared too early");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

endmodule

bind indexed_list_store_core ils_checker #(.CAPACITY(CAPACITY)) u_ils_checker (.*);
